// ----- sv/twm_pkg.sv -----
package twm_pkg;

  // list geometry
  localparam int MAX_LEN   = 16;
  localparam int NUM_LISTS = 3;
  localparam int LEN_W     = 5;
  localparam int ADDR_W    = 4;
  localparam int CNT_W     = 6;
  localparam int DATA_W    = 32;

  // list id that carries no list
  localparam logic [1:0] LIST_NONE = 2'd3;

  // back-end states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PRIME = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;

  // command passed from front to back
  typedef struct packed {
    logic              wr_en;
    logic [1:0]        list;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
    logic              merge;
  } cmd_t;

  // list length as used: zero acts as one, large values clip to MAX_LEN
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n == '0) n = LEN_W'(1);
    if (n > LEN_W'(MAX_LEN)) n = LEN_W'(MAX_LEN);
    return n;
  endfunction

endpackage

// ----- sv/three_way_merge_top.sv -----
// Channel   Direction  Handshake                    Payload
// in_       input      start high, busy low          in_list_id, in_elem_value
// out_      output     out_valid                    out_merged_value, out_final_flag
// cfg_      input      cfg_we                        cfg_wdata (list_len)
//
// Load beats are taken one per cycle while busy is low; each beat that is kept
// passes through a two-entry command queue to the back end, which writes it into
// its list memory. The completing beat starts a merge: the back end pops and
// writes it, primes the read heads and registers the first pick, then streams
// 3*eff_len(list_len) result beats, one per cycle. Busy stays high until the last
// one.
// Reset is synchronous on rst_n; list_len resets to 4. The receiver cannot stall.
module three_way_merge_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_list_id,
  input  logic signed [31:0]        in_elem_value,
  output logic                      out_valid,
  output logic signed [31:0]        out_merged_value,
  output logic                      out_final_flag,
  input  logic                      cfg_we,
  input  logic [twm_pkg::LEN_W-1:0] cfg_wdata
);
  import twm_pkg::*;

  cmd_t             push_cmd, q_cmd;
  logic             push, pop, q_valid, q_full;
  logic [LEN_W-1:0] n_eff;
  logic             merge_done;

  assign merge_done = out_valid & out_final_flag;

  twm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_list_id    (in_list_id),
    .in_elem_value (in_elem_value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .q_full        (q_full),
    .merge_done    (merge_done),
    .busy          (busy),
    .push          (push),
    .cmd           (push_cmd),
    .n_eff         (n_eff)
  );

  twm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_cmd    (q_cmd)
  );

  twm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .n_eff            (n_eff),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_merged_value (out_merged_value),
    .out_final_flag   (out_final_flag)
  );

  // results only stream while a merge holds the input off
  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while input open");

  // final flag only on a result beat
  a_final_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_final_flag |-> out_valid)
    else $error("final flag without result beat");

  // nothing follows the last beat of a merge
  a_quiet_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_flag) |=> (!out_valid && !busy))
    else $error("activity after final beat");

  // the queue never overflows while loading
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("push into full command queue");

endmodule

// ----- sv/twm_front.sv -----
module twm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [1:0]                  in_list_id,
  input  logic signed [31:0]          in_elem_value,
  input  logic                        cfg_we,
  input  logic [twm_pkg::LEN_W-1:0]   cfg_wdata,
  input  logic                        q_full,
  input  logic                        merge_done,
  output logic                        busy,
  output logic                        push,
  output twm_pkg::cmd_t               cmd,
  output logic [twm_pkg::LEN_W-1:0]   n_eff
);
  import twm_pkg::*;

  logic [LEN_W-1:0] list_len_r;
  logic [LEN_W-1:0] fill_r   [NUM_LISTS];
  logic [LEN_W-1:0] fill_nxt [NUM_LISTS];
  logic             pend_r, pend_nxt;
  logic             accept;
  logic             all_full;

  assign n_eff  = eff_len(list_len_r);
  assign busy   = pend_r | q_full;
  assign accept = start & ~busy;

  // classify the beat: store write, drop, and completion check
  always_comb begin
    fill_nxt     = fill_r;
    pend_nxt     = pend_r & ~merge_done;
    cmd.wr_en    = 1'b0;
    cmd.list     = in_list_id;
    cmd.addr     = '0;
    cmd.value    = in_elem_value;
    cmd.merge    = 1'b0;
    all_full     = 1'b1;
    push         = 1'b0;
    if (accept && in_list_id != LIST_NONE) begin
      for (int p = 0; p < NUM_LISTS; p++) begin
        if (in_list_id == 2'(p) && fill_r[p] < n_eff) begin
          cmd.wr_en   = 1'b1;
          cmd.addr    = fill_r[p][ADDR_W-1:0];
          fill_nxt[p] = fill_r[p] + LEN_W'(1);
        end
      end
      for (int p = 0; p < NUM_LISTS; p++) begin
        if (fill_nxt[p] < n_eff) all_full = 1'b0;
      end
      if (all_full) begin
        cmd.merge = 1'b1;
        pend_nxt  = 1'b1;
        for (int p = 0; p < NUM_LISTS; p++) fill_nxt[p] = '0;
      end
      push = cmd.wr_en | cmd.merge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_len_r <= LEN_W'(4);
      pend_r     <= 1'b0;
      for (int p = 0; p < NUM_LISTS; p++) fill_r[p] <= '0;
    end else begin
      if (cfg_we) list_len_r <= cfg_wdata;
      pend_r <= pend_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

// ----- sv/twm_queue.sv -----
module twm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  twm_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          q_valid,
  output logic          q_full,
  output twm_pkg::cmd_t q_cmd
);
  import twm_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign q_valid = (count_r != 2'd0);
  assign q_full  = (count_r == 2'd2);
  assign q_cmd   = slot_r[rd_ptr_r];
  assign do_push = push & ~q_full;
  assign do_pop  = pop & q_valid;

  // payload slots
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- sv/twm_back.sv -----
module twm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  twm_pkg::cmd_t               q_cmd,
  input  logic [twm_pkg::LEN_W-1:0]   n_eff,
  output logic                        pop,
  output logic                        out_valid,
  output logic signed [31:0]          out_merged_value,
  output logic                        out_final_flag
);
  import twm_pkg::*;

  logic [1:0]              state_r, state_nxt;
  logic [DATA_W-1:0]       mem0 [MAX_LEN];
  logic [DATA_W-1:0]       mem1 [MAX_LEN];
  logic [DATA_W-1:0]       mem2 [MAX_LEN];
  logic signed [DATA_W-1:0] head_r [NUM_LISTS];
  logic [LEN_W-1:0]        idx_r   [NUM_LISTS];
  logic [LEN_W-1:0]        idx_nxt [NUM_LISTS];
  logic [ADDR_W-1:0]       rd_addr [NUM_LISTS];
  logic [NUM_LISTS-1:0]    avail, take;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt, total;
  logic                    last;
  logic signed [DATA_W-1:0] sel_val;
  logic                    out_valid_r, out_final_r;
  logic signed [DATA_W-1:0] out_value_r;

  assign pop   = q_valid & (state_r == ST_IDLE);
  assign total = CNT_W'(n_eff) + (CNT_W'(n_eff) << 1);
  assign last  = (cnt_r == total - CNT_W'(1));

  // pick the smallest head; lower list wins ties
  always_comb begin
    for (int p = 0; p < NUM_LISTS; p++) avail[p] = (idx_r[p] < n_eff);
    take    = '0;
    sel_val = head_r[2];
    if (avail[0] && (!avail[1] || head_r[0] <= head_r[1])
                 && (!avail[2] || head_r[0] <= head_r[2])) begin
      take[0] = 1'b1;
      sel_val = head_r[0];
    end else if (avail[1] && (!avail[2] || head_r[1] <= head_r[2])) begin
      take[1] = 1'b1;
      sel_val = head_r[1];
    end else begin
      take[2] = avail[2];
    end
  end

  // sequencer and read pointers
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    for (int p = 0; p < NUM_LISTS; p++) idx_nxt[p] = idx_r[p];
    unique case (state_r)
      ST_IDLE: begin
        if (pop && q_cmd.merge) state_nxt = ST_PRIME;
      end
      ST_PRIME: begin
        for (int p = 0; p < NUM_LISTS; p++) idx_nxt[p] = '0;
        cnt_nxt   = '0;
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        for (int p = 0; p < NUM_LISTS; p++) idx_nxt[p] = idx_r[p] + LEN_W'(take[p]);
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    for (int p = 0; p < NUM_LISTS; p++) rd_addr[p] = idx_nxt[p][ADDR_W-1:0];
  end

  // list memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (pop && q_cmd.wr_en && q_cmd.list == 2'd0) mem0[q_cmd.addr] <= q_cmd.value;
    head_r[0] <= mem0[rd_addr[0]];
  end

  always_ff @(posedge clk) begin
    if (pop && q_cmd.wr_en && q_cmd.list == 2'd1) mem1[q_cmd.addr] <= q_cmd.value;
    head_r[1] <= mem1[rd_addr[1]];
  end

  always_ff @(posedge clk) begin
    if (pop && q_cmd.wr_en && q_cmd.list == 2'd2) mem2[q_cmd.addr] <= q_cmd.value;
    head_r[2] <= mem2[rd_addr[2]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < NUM_LISTS; p++) idx_r[p] <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= (state_r == ST_MERGE);
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    out_value_r <= sel_val;
    out_final_r <= (state_r == ST_MERGE) & last;
  end

  assign out_valid        = out_valid_r;
  assign out_merged_value = out_value_r;
  assign out_final_flag   = out_final_r;

endmodule
